>>> rtl/core/timed_event_queue_macros.svh
`ifndef TIMED_EVENT_QUEUE_MACROS_SVH
`define TIMED_EVENT_QUEUE_MACROS_SVH

// same-cycle implication
`define TEQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TEQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/teq_pkg.sv
package teq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int IN_W      = 112;
    localparam int OUT_W     = 240;

    typedef enum logic [2:0] {
        FN_SCHED  = 3'd0,
        FN_CANCEL = 3'd1,
        FN_CALL   = 3'd2,
        FN_QUERY  = 3'd3,
        FN_ADV    = 3'd4,
        FN_JUMP   = 3'd5,
        FN_CLEAR  = 3'd6,
        FN_FIRE   = 3'd7
    } func_t;

    typedef enum logic [1:0] {
        KIND_DONE  = 2'd0,
        KIND_FIRED = 2'd1,
        KIND_FULL  = 2'd2,
        KIND_BACK  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [63:0] due;
        logic [7:0]  owner;
        logic [31:0] arg;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCH_RD,
        ST_SCH_WR,
        ST_SCH_NEW,
        ST_CMP_RD,
        ST_CMP_WR,
        ST_FS_RD,
        ST_FS_CHK,
        ST_FE_RD,
        ST_FE_OUT,
        ST_RESP
    } state_t;

endpackage

>>> rtl/core/teq_ram.sv
module teq_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [$clog2(D)-1:0] wr_addr,
    input  logic [W-1:0]         wr_data,
    input  logic                 rd_en,
    input  logic [$clog2(D)-1:0] rd_addr,
    output logic [W-1:0]         rd_data
);

    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/core/timed_event_queue.sv
// Timed event queue: a current time plus up to DEPTH events kept sorted by due
// time in one RAM (ties keep arrival order).
// Input channel s_*: one word per operation (schedule, cancel, cancel all,
// query, advance, jump, clear, fire). s_tready is high only while the block
// is idle, so one operation is worked at a time.
// Output channel m_*: one word per result, tlast on the final one; tuser
// carries the result kind. A single output register sits between the engine
// and the receiver; a stalled receiver holds the engine in place.
// Work per operation, with N entries queued:
//   advance, jump, clear, cancel all, schedule into a full queue: no RAM access
//   schedule: a direct write when empty, else a shift-up walk from the top,
//   one entry per read/write pair through the RAM port pair
//   cancel, query: full walk of the RAM
//   fire with nothing due: a check of the head entry (no read when empty)
//   fire of F > 0 due events: a scan up to the first entry not yet due,
//   then F emitted words, then compaction of the N-F entries left
// Reset clears the count, the time and the earliest-due register; RAM
// contents need no clearing since only entries below the count are read.
module timed_event_queue #(
    parameter int DEPTH = teq_pkg::DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // func[2:0], handler_id[10:3], param[42:11], amount[106:43]
    input  logic [teq_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // fired_handler[7:0], fired_param[39:8], event_time[103:40],
    // now_time[167:104], pending[168], next_due[232:169]
    output logic [teq_pkg::OUT_W-1:0] m_tdata,
    // kind[1:0]
    output logic [1:0]                m_tuser,
    output logic                      m_tlast
);

    import teq_pkg::*;

`include "timed_event_queue_macros.svh"

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] widx_reg, widx_next;
    logic [CW-1:0] fcnt_reg, fcnt_next;
    logic [63:0]   now_reg, now_next;
    logic [63:0]   early_reg, early_next;
    logic [63:0]   due_reg, due_next;
    logic [7:0]    h_reg, h_next;
    logic [31:0]   p_reg, p_next;
    func_t         func_reg, func_next;
    kind_t         rkind_reg, rkind_next;
    logic          found_reg, found_next;

    logic          mv_reg, mv_next;
    kind_t         okind_reg, okind_next;
    logic [7:0]    oh_reg, oh_next;
    logic [31:0]   op_reg, op_next;
    logic [63:0]   oevt_reg, oevt_next;
    logic [63:0]   onow_reg, onow_next;
    logic          opend_reg, opend_next;
    logic [63:0]   ond_reg, ond_next;
    logic          olast_reg, olast_next;

    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    entry_t        wr_data, rd_data;
    logic [ENTRY_W-1:0] rd_raw;

    logic [2:0]    in_func;
    logic [7:0]    in_h;
    logic [31:0]   in_p;
    logic [63:0]   in_amt;
    logic [63:0]   sum;
    logic          out_free;
    logic          match;
    entry_t        new_entry;

    assign in_func  = s_tdata[2:0];
    assign in_h     = s_tdata[10:3];
    assign in_p     = s_tdata[42:11];
    assign in_amt   = s_tdata[106:43];
    assign sum      = now_reg + in_amt;
    assign out_free = !mv_reg || m_tready;
    assign rd_data  = entry_t'(rd_raw);
    assign match    = (rd_data.owner == h_reg) && (rd_data.arg == p_reg);
    assign new_entry = '{due: due_reg, owner: h_reg, arg: p_reg};

    teq_ram #(
        .W (ENTRY_W),
        .D (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        widx_next  = widx_reg;
        fcnt_next  = fcnt_reg;
        now_next   = now_reg;
        early_next = early_reg;
        due_next   = due_reg;
        h_next     = h_reg;
        p_next     = p_reg;
        func_next  = func_reg;
        rkind_next = rkind_reg;
        found_next = found_reg;
        mv_next    = mv_reg && !m_tready;
        okind_next = okind_reg;
        oh_next    = oh_reg;
        op_next    = op_reg;
        oevt_next  = oevt_reg;
        onow_next  = onow_reg;
        opend_next = opend_reg;
        ond_next   = ond_reg;
        olast_next = olast_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    func_next  = func_t'(in_func);
                    h_next     = in_h;
                    p_next     = in_p;
                    rkind_next = KIND_DONE;
                    found_next = 1'b0;
                    idx_next   = '0;
                    widx_next  = '0;
                    due_next   = (sum == 64'd0) ? 64'd1 : sum;
                    state_next = ST_RESP;
                    unique case (func_t'(in_func))
                        FN_SCHED:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                rkind_next = KIND_FULL;
                            end
                            else if (count_reg == '0)
                            begin
                                state_next = ST_SCH_NEW;
                            end
                            else
                            begin
                                idx_next   = count_reg - CW'(1);
                                state_next = ST_SCH_RD;
                            end
                        end
                        FN_CANCEL, FN_QUERY:
                        begin
                            state_next = ST_CMP_RD;
                        end
                        FN_CALL:
                        begin
                            count_next = '0;
                            early_next = '0;
                        end
                        FN_ADV:
                        begin
                            now_next = sum;
                        end
                        FN_JUMP:
                        begin
                            if (in_amt < now_reg)
                            begin
                                rkind_next = KIND_BACK;
                            end
                            else
                            begin
                                now_next = in_amt;
                            end
                        end
                        FN_CLEAR:
                        begin
                            count_next = '0;
                            early_next = '0;
                            now_next   = '0;
                        end
                        FN_FIRE:
                        begin
                            state_next = ST_FS_RD;
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_SCH_RD:
            begin
                state_next = ST_SCH_WR;
            end
            ST_SCH_WR:
            begin
                if (rd_data.due > due_reg)
                begin
                    if (idx_reg == '0)
                    begin
                        state_next = ST_SCH_NEW;
                    end
                    else
                    begin
                        idx_next   = idx_reg - CW'(1);
                        state_next = ST_SCH_RD;
                    end
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                    state_next = ST_RESP;
                end
            end
            ST_SCH_NEW:
            begin
                count_next = count_reg + CW'(1);
                early_next = due_reg;
                state_next = ST_RESP;
            end
            ST_CMP_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    if (func_reg != FN_QUERY)
                    begin
                        count_next = widx_reg;
                        if (widx_reg == '0)
                        begin
                            early_next = '0;
                        end
                    end
                    state_next = (func_reg == FN_FIRE) ? ST_IDLE : ST_RESP;
                end
                else
                begin
                    state_next = ST_CMP_WR;
                end
            end
            ST_CMP_WR:
            begin
                idx_next   = idx_reg + CW'(1);
                state_next = ST_CMP_RD;
                if (func_reg == FN_QUERY)
                begin
                    found_next = found_reg || match;
                end
                else if (func_reg == FN_FIRE || !match)
                begin
                    widx_next = widx_reg + CW'(1);
                    if (widx_reg == '0)
                    begin
                        early_next = rd_data.due;
                    end
                end
            end
            ST_FS_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    early_next = '0;
                    fcnt_next  = idx_reg;
                    idx_next   = '0;
                    state_next = (idx_reg == '0) ? ST_RESP : ST_FE_RD;
                end
                else
                begin
                    state_next = ST_FS_CHK;
                end
            end
            ST_FS_CHK:
            begin
                if (rd_data.due <= now_reg)
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = ST_FS_RD;
                end
                else
                begin
                    early_next = rd_data.due;
                    fcnt_next  = idx_reg;
                    idx_next   = '0;
                    state_next = (idx_reg == '0) ? ST_RESP : ST_FE_RD;
                end
            end
            ST_FE_RD:
            begin
                state_next = ST_FE_OUT;
            end
            ST_FE_OUT:
            begin
                if (out_free)
                begin
                    mv_next    = 1'b1;
                    okind_next = KIND_FIRED;
                    oh_next    = rd_data.owner;
                    op_next    = rd_data.arg;
                    oevt_next  = rd_data.due;
                    onow_next  = now_reg;
                    opend_next = 1'b0;
                    ond_next   = early_reg;
                    olast_next = (idx_reg + CW'(1) == fcnt_reg);
                    if (idx_reg + CW'(1) == fcnt_reg)
                    begin
                        idx_next   = fcnt_reg;
                        widx_next  = '0;
                        state_next = ST_CMP_RD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CW'(1);
                        state_next = ST_FE_RD;
                    end
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    mv_next    = 1'b1;
                    okind_next = rkind_reg;
                    oh_next    = '0;
                    op_next    = '0;
                    oevt_next  = (func_reg == FN_SCHED) ? due_reg : 64'd0;
                    onow_next  = now_reg;
                    opend_next = (func_reg == FN_QUERY) && found_reg;
                    ond_next   = early_reg;
                    olast_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = (state_reg == ST_IDLE);
        rd_en    = 1'b0;
        rd_addr  = idx_reg[AW-1:0];
        wr_en    = 1'b0;
        wr_addr  = '0;
        wr_data  = new_entry;
        unique case (state_reg)
            ST_SCH_RD, ST_FS_RD, ST_FE_RD:
            begin
                rd_en = (state_reg != ST_FS_RD) || (idx_reg != count_reg);
            end
            ST_CMP_RD:
            begin
                rd_en = (idx_reg != count_reg);
            end
            ST_SCH_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = AW'(idx_reg + CW'(1));
                wr_data = (rd_data.due > due_reg) ? rd_data : new_entry;
            end
            ST_SCH_NEW:
            begin
                wr_en = 1'b1;
            end
            ST_CMP_WR:
            begin
                wr_en   = (func_reg == FN_FIRE) || (func_reg == FN_CANCEL && !match);
                wr_addr = widx_reg[AW-1:0];
                wr_data = rd_data;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            now_reg   <= '0;
            early_reg <= '0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            now_reg   <= now_next;
            early_reg <= early_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        widx_reg  <= widx_next;
        fcnt_reg  <= fcnt_next;
        due_reg   <= due_next;
        h_reg     <= h_next;
        p_reg     <= p_next;
        func_reg  <= func_next;
        rkind_reg <= rkind_next;
        found_reg <= found_next;
        okind_reg <= okind_next;
        oh_reg    <= oh_next;
        op_reg    <= op_next;
        oevt_reg  <= oevt_next;
        onow_reg  <= onow_next;
        opend_reg <= opend_next;
        ond_reg   <= ond_next;
        olast_reg <= olast_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tuser  = okind_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {7'd0, ond_reg, opend_reg, onow_reg, oevt_reg, op_reg, oh_reg};

    `TEQ_ASSERT_IMP(a_count_max, 1'b1, count_reg <= CW'(DEPTH), "entry count over depth")
    `TEQ_ASSERT_IMP(a_early_empty, state_reg == ST_IDLE,
        (count_reg == '0) == (early_reg == 64'd0), "earliest due out of step with count")
    `TEQ_ASSERT_IMP(a_fired_due, mv_reg && okind_reg == KIND_FIRED,
        oevt_reg <= onow_reg, "fired event not yet due")
    `TEQ_ASSERT_NXT(a_busy, s_tvalid && s_tready, state_reg != ST_IDLE,
        "operation accepted without leaving idle")

endmodule
